// ----- rtl/ptst_pkg.sv -----
// Package: state codes, register indexes and constants of the pan/tilt servo tracker.
`default_nettype none

package ptst_pkg;

	localparam int unsigned ANGLE_W   = 8;
	localparam int unsigned PULSE_W   = 11;
	localparam int unsigned OFFSET_W  = 12;
	localparam int unsigned GAIN_W    = 12;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 12;
	localparam int unsigned MUL_W     = 24;
	localparam int unsigned PROD_W    = 2 * MUL_W;
	localparam int unsigned MAG_W     = 46;
	localparam int unsigned THR2_W    = 32;
	localparam int unsigned STEP_W    = 16;
	localparam int unsigned SUM_W     = 18;

	localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;
	localparam logic [PULSE_W-1:0] PULSE_BASE  = 11'd1000;
	// floor(a*1000/180) == (a * PULSE_RECIP) >> 16 for every a in 0..180
	localparam logic [MUL_W-1:0]   PULSE_RECIP = 24'd364100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_X    = 3'd0,
		REG_GAIN_Y    = 3'd1,
		REG_DEAD_BAND = 3'd2,
		REG_PAN_MIN   = 3'd3,
		REG_PAN_MAX   = 3'd4,
		REG_TILT_MIN  = 3'd5,
		REG_TILT_MAX  = 3'd6
	} reg_idx_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MULX = 9'b000000010,
		S_MULY = 9'b000000100,
		S_SQX  = 9'b000001000,
		S_SQY  = 9'b000010000,
		S_THR  = 9'b000100000,
		S_UPD  = 9'b001000000,
		S_PLX  = 9'b010000000,
		S_PLY  = 9'b100000000
	} state_t;

	// Clip a written limit to the top of the servo range.
	function automatic logic [ANGLE_W-1:0] sat180(input logic [CFG_DAT_W-1:0] v);
		logic [ANGLE_W-1:0] lo;
		lo = v[ANGLE_W-1:0];
		return (lo > ANGLE_LIMIT) ? ANGLE_LIMIT : lo;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pan_tilt_servo_tracker.sv -----
// Top level: pan/tilt servo tracker with one shared multiplier under a sequencer.
// Sequencer steps from input acceptance to the output register: MULX, MULY, SQX,
// SQY, THR, UPD, PLX, PLY, one transaction at a time; the single 24x24 multiplier
// serves seven steps (two gains, two squares, threshold square, two pulses).
// Input stall is high while a transaction is in work; the output register lets the
// next transaction start while the previous result waits to be taken.
// Reset (arst_n low, asynchronous): registers to their defaults, angles to home.
`default_nettype none

module pan_tilt_servo_tracker #(
	parameter int unsigned HOME_X = 90,
	parameter int unsigned HOME_Y = 90
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write port
	input  wire                                   cfg_wr_en,
	input  wire        [ptst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire        [ptst_pkg::CFG_DAT_W-1:0]  cfg_data,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire signed [ptst_pkg::OFFSET_W-1:0]   offset_x,
	input  wire signed [ptst_pkg::OFFSET_W-1:0]   offset_y,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic       [ptst_pkg::PULSE_W-1:0]    pulse_x,
	output logic       [ptst_pkg::PULSE_W-1:0]    pulse_y,
	output logic       [ptst_pkg::ANGLE_W-1:0]    angle_x,
	output logic       [ptst_pkg::ANGLE_W-1:0]    angle_y,
	output logic                                  moved,
	output logic                                  limit_x,
	output logic                                  limit_y
);
	import ptst_pkg::*;

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_x_q, gain_y_q;
	logic        [ANGLE_W-1:0] dead_band_q;
	logic        [ANGLE_W-1:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;

	// servo state
	logic [ANGLE_W-1:0] pan_angle_q, tilt_angle_q;

	// sequencer and working registers
	state_t                     state_q;
	logic signed [OFFSET_W-1:0] ox_q, oy_q;
	logic signed [MUL_W-1:0]    sx_q, sy_q;
	logic        [MAG_W-1:0]    mag_q;
	logic        [THR2_W-1:0]   thr2_q;
	logic                       moved_q, lim_x_q, lim_y_q;
	logic        [PULSE_W-1:0]  pulse_x_q;

	// output register
	logic                       out_valid_q;
	logic        [PULSE_W-1:0]  out_pulse_x_q, out_pulse_y_q;
	logic        [ANGLE_W-1:0]  out_angle_x_q, out_angle_y_q;
	logic                       out_moved_q, out_lim_x_q, out_lim_y_q;

	// shared multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic in_take, out_free;
	logic [PULSE_W-1:0] pulse_now;

	// axis step and clamp
	logic signed [STEP_W-1:0] step_x, step_y;
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic [ANGLE_W-1:0]       nxt_x, nxt_y;
	logic                     hit_x, hit_y;
	logic                     over_band;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	// the output slot can take a new result when empty or being emptied now
	assign out_free = !out_valid_q || !out_stall;

	// Route operands to the multiplier by sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = MUL_W'(ox_q);
				mul_b = MUL_W'(gain_x_q);
			end
			S_MULY: begin
				mul_a = MUL_W'(oy_q);
				mul_b = MUL_W'(gain_y_q);
			end
			S_SQX: begin
				mul_a = sx_q;
				mul_b = sx_q;
			end
			S_SQY: begin
				mul_a = sy_q;
				mul_b = sy_q;
			end
			S_THR: begin
				// threshold in Q.8 is dead_band * 256
				mul_a = $signed({8'b0, dead_band_q, 8'b0});
				mul_b = $signed({8'b0, dead_band_q, 8'b0});
			end
			S_PLX: begin
				mul_a = $signed({16'b0, pan_angle_q});
				mul_b = $signed(PULSE_RECIP);
			end
			S_PLY: begin
				mul_a = $signed({16'b0, tilt_angle_q});
				mul_b = $signed(PULSE_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign pulse_now = PULSE_BASE + {1'b0, mul_p[25:16]};

	// Whole-degree steps: shift down, then round negative values toward zero.
	always_comb begin
		step_x = STEP_W'(sx_q >>> 8);
		if (sx_q[MUL_W-1] && (sx_q[7:0] != 8'd0))
			step_x = step_x + STEP_W'(1);
		step_y = STEP_W'(sy_q >>> 8);
		if (sy_q[MUL_W-1] && (sy_q[7:0] != 8'd0))
			step_y = step_y + STEP_W'(1);
	end

	assign sum_x = $signed({{(SUM_W-ANGLE_W){1'b0}}, pan_angle_q}) + SUM_W'(step_x);
	assign sum_y = $signed({{(SUM_W-ANGLE_W){1'b0}}, tilt_angle_q}) + SUM_W'(step_y);

	// Upper limit is tested first; a min above max thus lands on max.
	always_comb begin
		hit_x = 1'b1;
		if (sum_x >= $signed({{(SUM_W-ANGLE_W){1'b0}}, pan_max_q}))
			nxt_x = pan_max_q;
		else if (sum_x <= $signed({{(SUM_W-ANGLE_W){1'b0}}, pan_min_q}))
			nxt_x = pan_min_q;
		else begin
			nxt_x = sum_x[ANGLE_W-1:0];
			hit_x = 1'b0;
		end
		hit_y = 1'b1;
		if (sum_y >= $signed({{(SUM_W-ANGLE_W){1'b0}}, tilt_max_q}))
			nxt_y = tilt_max_q;
		else if (sum_y <= $signed({{(SUM_W-ANGLE_W){1'b0}}, tilt_min_q}))
			nxt_y = tilt_min_q;
		else begin
			nxt_y = sum_y[ANGLE_W-1:0];
			hit_y = 1'b0;
		end
	end

	assign over_band = (mag_q > MAG_W'(thr2_q));

	// Configuration writes; unknown indexes fall through and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q    <= -12'sd51;
			gain_y_q    <= 12'sd154;
			dead_band_q <= 8'd20;
			pan_min_q   <= 8'd0;
			pan_max_q   <= ANGLE_LIMIT;
			tilt_min_q  <= 8'd0;
			tilt_max_q  <= ANGLE_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_X:    gain_x_q    <= $signed(cfg_data);
				REG_GAIN_Y:    gain_y_q    <= $signed(cfg_data);
				REG_DEAD_BAND: dead_band_q <= cfg_data[ANGLE_W-1:0];
				REG_PAN_MIN:   pan_min_q   <= sat180(cfg_data);
				REG_PAN_MAX:   pan_max_q   <= sat180(cfg_data);
				REG_TILT_MIN:  tilt_min_q  <= sat180(cfg_data);
				REG_TILT_MAX:  tilt_max_q  <= sat180(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Sequencer and servo state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pan_angle_q  <= ANGLE_W'(HOME_X);
			tilt_angle_q <= ANGLE_W'(HOME_Y);
		end else begin
			case (state_q)
				S_IDLE: if (in_take) state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_THR;
				S_THR:  state_q <= S_UPD;
				S_UPD: begin
					if (over_band) begin
						pan_angle_q  <= nxt_x;
						tilt_angle_q <= nxt_y;
					end
					state_q <= S_PLX;
				end
				S_PLX:  state_q <= S_PLY;
				// hold here until the output slot frees up
				S_PLY:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working payload registers; no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			ox_q <= offset_x;
			oy_q <= offset_y;
		end
		case (state_q)
			S_MULX: sx_q <= mul_p[MUL_W-1:0];
			S_MULY: sy_q <= mul_p[MUL_W-1:0];
			S_SQX:  mag_q <= mul_p[MAG_W-1:0];
			S_SQY:  mag_q <= mag_q + mul_p[MAG_W-1:0];
			S_THR:  thr2_q <= mul_p[THR2_W-1:0];
			S_UPD: begin
				moved_q <= over_band;
				lim_x_q <= over_band && hit_x;
				lim_y_q <= over_band && hit_y;
			end
			S_PLX:  pulse_x_q <= pulse_now;
			default: begin
			end
		endcase
	end

	// Output register: load on the last step, clear when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_PLY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_PLY) && out_free) begin
			out_pulse_x_q <= pulse_x_q;
			out_pulse_y_q <= pulse_now;
			out_angle_x_q <= pan_angle_q;
			out_angle_y_q <= tilt_angle_q;
			out_moved_q   <= moved_q;
			out_lim_x_q   <= lim_x_q;
			out_lim_y_q   <= lim_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pulse_x   = out_pulse_x_q;
	assign pulse_y   = out_pulse_y_q;
	assign angle_x   = out_angle_x_q;
	assign angle_y   = out_angle_y_q;
	assign moved     = out_moved_q;
	assign limit_x   = out_lim_x_q;
	assign limit_y   = out_lim_y_q;

	// Checks on the sequencer and result register.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_MULX))
		else $error("accepted transaction did not start the sequencer");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PLY))
		else $error("result appeared outside the final step");

	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(pan_angle_q <= ANGLE_LIMIT) && (tilt_angle_q <= ANGLE_LIMIT))
		else $error("servo angle beyond range");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_moved_q) |-> (!out_lim_x_q && !out_lim_y_q))
		else $error("limit flag without movement");

	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_pulse_x_q >= PULSE_BASE) && (out_pulse_x_q <= 11'd2000)
			&& (out_pulse_y_q >= PULSE_BASE) && (out_pulse_y_q <= 11'd2000)))
		else $error("pulse width out of servo range");

endmodule

`default_nettype wire

// ----- verif/pan_tilt_servo_tracker_tb.sv -----
// Testbench: pan/tilt servo tracker checked against a behavioral tracking predictor.
`timescale 1ns / 1ps

module pan_tilt_servo_tracker_tb;
	import ptst_pkg::*;

	localparam int HOME_X         = 90;
	localparam int HOME_Y         = 90;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 100;
	localparam int RANDOM_PHASES  = 10;
	// No register lives at this index; a write to it must leave everything alone.
	localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;

	typedef struct {
		logic [OFFSET_W-1:0] ox;
		logic [OFFSET_W-1:0] oy;
	} target_t;

	typedef struct {
		logic [PULSE_W-1:0] pulse_x;
		logic [PULSE_W-1:0] pulse_y;
		logic [ANGLE_W-1:0] angle_x;
		logic [ANGLE_W-1:0] angle_y;
		logic               moved;
		logic               limit_x;
		logic               limit_y;
	} servo_rec_t;

	// DUT connections; every input starts at a known value.
	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DAT_W-1:0]        cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic signed [OFFSET_W-1:0]  offset_x  = '0;
	logic signed [OFFSET_W-1:0]  offset_y  = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [PULSE_W-1:0]          pulse_x;
	logic [PULSE_W-1:0]          pulse_y;
	logic [ANGLE_W-1:0]          angle_x;
	logic [ANGLE_W-1:0]          angle_y;
	logic                        moved;
	logic                        limit_x;
	logic                        limit_y;

	// Predictor copy of the register file and the servo angles.
	logic signed [GAIN_W-1:0] pan_gain  = -12'sd51;
	logic signed [GAIN_W-1:0] tilt_gain = 12'sd154;
	logic [ANGLE_W-1:0]       band      = 8'd20;
	logic [ANGLE_W-1:0]       pan_lo    = 8'd0;
	logic [ANGLE_W-1:0]       pan_hi    = 8'd180;
	logic [ANGLE_W-1:0]       tilt_lo   = 8'd0;
	logic [ANGLE_W-1:0]       tilt_hi   = 8'd180;
	int                       pan_deg   = HOME_X;
	int                       tilt_deg  = HOME_Y;

	target_t    aim_queue[$];   // offsets waiting to be driven
	servo_rec_t servo_due[$];   // predicted servo results, oldest first
	target_t    next_aim;
	servo_rec_t want;
	servo_rec_t got;

	bit in_took     = 1'b0;
	bit out_took    = 1'b0;
	bit feed_idle   = 1'b1;
	bit drain_idle  = 1'b1;
	int feed_wait   = 0;
	int drain_hold  = 0;
	int stuck_count = 0;
	int miss_count  = 0;

	pan_tilt_servo_tracker #(
		.HOME_X(HOME_X),
		.HOME_Y(HOME_Y)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.offset_x (offset_x),
		.offset_y (offset_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_x  (pulse_x),
		.pulse_y  (pulse_y),
		.angle_x  (angle_x),
		.angle_y  (angle_y),
		.moved    (moved),
		.limit_x  (limit_x),
		.limit_y  (limit_y)
	);

	always #10 clk = ~clk;

	task automatic log_miss(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		miss_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] seen, input logic [15:0] need);
		if (seen !== need)
			log_miss($sformatf("%s got %0d, predicted %0d", name, seen, need));
	endtask

	// Max test comes before min test, so a min above max still resolves to max.
	function automatic int clamp_angle(input int ang, input longint step, input int lo,
			input int hi, output bit hit);
		longint t;
		t = ang + step;
		hit = 1'b1;
		if (t >= hi)
			return hi;
		if (t <= lo)
			return lo;
		hit = 1'b0;
		return int'(t);
	endfunction

	// Advance the predicted angles by one offset pair and build the servo result.
	task automatic track_step(input logic signed [OFFSET_W-1:0] ox,
			input logic signed [OFFSET_W-1:0] oy, output servo_rec_t r);
		longint sx, sy, mag2, thr;
		bit hx, hy;
		sx = longint'(ox) * longint'(pan_gain);
		sy = longint'(oy) * longint'(tilt_gain);
		mag2 = sx * sx + sy * sy;
		thr = longint'(band) * 256;
		hx = 1'b0;
		hy = 1'b0;
		r.moved = (mag2 > thr * thr);
		if (r.moved) begin
			// Q.8 step divided by 256 truncates toward zero, as the hardware does.
			pan_deg  = clamp_angle(pan_deg, sx / 256, int'(pan_lo), int'(pan_hi), hx);
			tilt_deg = clamp_angle(tilt_deg, sy / 256, int'(tilt_lo), int'(tilt_hi), hy);
		end
		r.limit_x = hx;
		r.limit_y = hy;
		r.angle_x = ANGLE_W'(pan_deg);
		r.angle_y = ANGLE_W'(tilt_deg);
		r.pulse_x = PULSE_W'(1000 + pan_deg * 1000 / 180);
		r.pulse_y = PULSE_W'(1000 + tilt_deg * 1000 / 180);
	endtask

	// Write one register and mirror it in the predictor; only called while idle.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		logic [ANGLE_W-1:0] lim;
		lim = (data[ANGLE_W-1:0] > ANGLE_LIMIT) ? ANGLE_LIMIT : data[ANGLE_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_GAIN_X:    pan_gain  = data;
			REG_GAIN_Y:    tilt_gain = data;
			REG_DEAD_BAND: band      = data[ANGLE_W-1:0];
			REG_PAN_MIN:   pan_lo    = lim;
			REG_PAN_MAX:   pan_hi    = lim;
			REG_TILT_MIN:  tilt_lo   = lim;
			REG_TILT_MAX:  tilt_hi   = lim;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic aim(input int x, input int y);
		target_t t;
		t.ox = OFFSET_W'(x);
		t.oy = OFFSET_W'(y);
		aim_queue.push_back(t);
	endtask

	// Hold until every queued offset is sent and every predicted result is back.
	task automatic wait_quiet();
		while (aim_queue.size() != 0 || in_valid || servo_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic int draw_wait(input bit on);
		return on ? $urandom_range(0, 19) : 0;
	endfunction

	// Mostly small gains so angles walk instead of slamming; sometimes full range or extremes.
	function automatic logic [CFG_DAT_W-1:0] pick_gain();
		logic [CFG_DAT_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = CFG_DAT_W'($urandom);
			1: v = $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
			default: v = CFG_DAT_W'($urandom_range(0, 128) - 64);
		endcase
		return v;
	endfunction

	// Full 12-bit draws hit limits above 180, above 255 and min over max.
	function automatic logic [CFG_DAT_W-1:0] pick_limit(input bit upper);
		logic [CFG_DAT_W-1:0] v;
		if ($urandom_range(0, 3) == 0)
			v = CFG_DAT_W'($urandom);
		else
			v = upper ? CFG_DAT_W'($urandom_range(90, 180))
				: CFG_DAT_W'($urandom_range(0, 90));
		return v;
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		logic [OFFSET_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = OFFSET_W'($urandom);
			1: v = OFFSET_W'($urandom_range(0, 510) - 255);
			default: v = OFFSET_W'($urandom_range(0, 62) - 31);
		endcase
		return v;
	endfunction

	// Input driver: after each accepted transaction, idle for a drawn number of cycles,
	// then present the next queued offset pair and hold it until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (feed_wait > 0) begin
				in_valid  <= 1'b0;
				feed_wait <= feed_wait - 1;
			end else if (aim_queue.size() != 0) begin
				next_aim = aim_queue.pop_front();
				offset_x  <= next_aim.ox;
				offset_y  <= next_aim.oy;
				in_valid  <= 1'b1;
				feed_wait <= draw_wait(feed_idle);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure: after each accepted result, stall for a drawn number of cycles.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_took)
				drain_hold = draw_wait(drain_idle);
			if (drain_hold > 0) begin
				out_stall <= 1'b1;
				drain_hold = drain_hold - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: predict on each accepted input, check each accepted result, and watch
	// for a stall in progress while work is still outstanding.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took     <= 1'b0;
			out_took    <= 1'b0;
			stuck_count <= 0;
		end else begin
			in_took  <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			// Check the result first so a same-edge input cannot be matched against it.
			if (out_valid && !out_stall) begin
				if (servo_due.size() == 0) begin
					log_miss("result with no transaction outstanding");
				end else begin
					want = servo_due.pop_front();
					got.pulse_x = pulse_x;
					got.pulse_y = pulse_y;
					got.angle_x = angle_x;
					got.angle_y = angle_y;
					got.moved   = moved;
					got.limit_x = limit_x;
					got.limit_y = limit_y;
					check_field("pulse_x", 16'(got.pulse_x), 16'(want.pulse_x));
					check_field("pulse_y", 16'(got.pulse_y), 16'(want.pulse_y));
					check_field("angle_x", 16'(got.angle_x), 16'(want.angle_x));
					check_field("angle_y", 16'(got.angle_y), 16'(want.angle_y));
					check_field("moved", 16'(got.moved), 16'(want.moved));
					check_field("limit_x", 16'(got.limit_x), 16'(want.limit_x));
					check_field("limit_y", 16'(got.limit_y), 16'(want.limit_y));
				end
			end
			if (in_valid && !in_stall) begin
				track_step(offset_x, offset_y, want);
				servo_due.push_back(want);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_count <= 0;
			end else if (aim_queue.size() != 0 || in_valid || servo_due.size() != 0) begin
				if (stuck_count + 1 >= WATCHDOG_LIMIT) begin
					$display("[pan_tilt_servo_tracker] ERROR");
					$finish;
				end else begin
					stuck_count <= stuck_count + 1;
				end
			end
		end
	end

	initial begin
		int ph, k;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero offset, sub-dead-band nudge, and the four offset corners.
		aim(0, 0);
		aim(1, 1);
		aim(2047, 2047);
		aim(-2048, -2048);
		aim(2047, -2048);
		aim(-2048, 2047);
		wait_quiet();

		// Unity pan gain, no tilt gain: land exactly on the dead band, then just past it.
		// Dead band written with junk in the upper bits, which must be dropped.
		reg_write(REG_GAIN_X, 12'h100);
		reg_write(REG_GAIN_Y, 12'h000);
		reg_write(REG_DEAD_BAND, 12'hF14);
		@(posedge clk);
		aim(20, 0);
		aim(21, -2048);
		aim(-21, 0);
		wait_quiet();

		// Tiny gains, zero dead band: negative steps truncate toward zero, a nonzero
		// product with a zero whole-degree step still counts as a move, zero does not.
		reg_write(REG_GAIN_X, 12'h001);
		reg_write(REG_GAIN_Y, 12'hFFF);
		reg_write(REG_DEAD_BAND, 12'h000);
		@(posedge clk);
		aim(-300, 0);
		aim(0, 300);
		aim(1, 0);
		aim(0, 0);
		wait_quiet();

		// Limits drop upper bits, then saturate above 180; tilt pinned with min and max both 180.
		// Extreme gains with the widest dead band; the unused index must change nothing.
		reg_write(REG_PAN_MAX, 12'd200);
		reg_write(REG_TILT_MAX, 12'hFFF);
		reg_write(REG_PAN_MIN, 12'h10A);
		reg_write(REG_TILT_MIN, 12'd181);
		reg_write(REG_GAIN_X, 12'h7FF);
		reg_write(REG_GAIN_Y, 12'h800);
		reg_write(REG_DEAD_BAND, 12'd255);
		reg_write(UNUSED_IDX, 12'h7FF);
		@(posedge clk);
		aim(2047, 2047);
		aim(-2048, -2048);
		aim(0, 1);
		aim(3, 0);
		wait_quiet();

		// Min above max on both axes: the max test wins.
		reg_write(REG_PAN_MIN, 12'd150);
		reg_write(REG_PAN_MAX, 12'd30);
		reg_write(REG_TILT_MIN, 12'd100);
		reg_write(REG_TILT_MAX, 12'd20);
		reg_write(REG_GAIN_X, 12'h010);
		reg_write(REG_GAIN_Y, 12'hFF0);
		reg_write(REG_DEAD_BAND, 12'd1);
		@(posedge clk);
		aim(200, -200);
		aim(-200, 200);
		aim(16, 0);
		wait_quiet();

		// Random phases: fresh register settings each time, mixed pacing on both sides.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			feed_idle  = (ph % 3) != 0;
			drain_idle = (ph % 4) != 1;
			reg_write(REG_GAIN_X, pick_gain());
			reg_write(REG_GAIN_Y, pick_gain());
			reg_write(REG_DEAD_BAND, ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom)
				: CFG_DAT_W'($urandom_range(0, 30)));
			reg_write(REG_PAN_MIN, pick_limit(1'b0));
			reg_write(REG_PAN_MAX, pick_limit(1'b1));
			reg_write(REG_TILT_MIN, pick_limit(1'b0));
			reg_write(REG_TILT_MAX, pick_limit(1'b1));
			if ($urandom_range(0, 3) == 0)
				reg_write(UNUSED_IDX, CFG_DAT_W'($urandom));
			@(posedge clk);
			for (k = 0; k < PHASE_ITEMS; k++)
				aim(signed'(pick_offset()), signed'(pick_offset()));
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (miss_count == 0 && servo_due.size() == 0)
			$display("[pan_tilt_servo_tracker] OK");
		else
			$display("[pan_tilt_servo_tracker] ERROR");
		$finish;
	end

endmodule
